@@ sv/plasma_pixel_color_assert.svh @@
// assertion macros shared by the plasma pixel colour checkers
// expects clk and arst_n in the scope of each use
`ifndef PLASMA_PIXEL_COLOR_ASSERT_SVH
`define PLASMA_PIXEL_COLOR_ASSERT_SVH

// checked only while out of reset
`define PPC_ASSERT_RUN(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// checked on every edge, reset included
`define PPC_ASSERT_ALL(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/ppc_pkg.sv @@
// constants and types for the plasma pixel colour block
// no dependencies
package ppc_pkg;

	localparam int FRAME_WIDTH_DEF  = 256;
	localparam int FRAME_HEIGHT_DEF = 256;
	// column and line are 8-bit fields
	localparam int COORD_RANGE = 256;

	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_ZERO  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_ONE   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_TWO   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_THREE = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SWEEP_ZERO = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SWEEP_ONE  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SWEEP_TWO  = 3'd6;

	localparam int NUM_CH   = 3;
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	// turn constants
	localparam logic [28:0] K_RATE        = 29'd273426110;
	localparam logic [24:0] K_RED_SWEEP   = 25'd33110193;
	localparam logic [27:0] K_GREEN_SWEEP = 28'd179435885;
	localparam logic [24:0] K_BLUE_SWEEP  = 25'd22429486;
	localparam logic [21:0] K_OUTER       = 22'd4192178;

	// sine polynomial, q.15
	localparam logic [15:0] SIN_A = 16'd51438;
	localparam logic [14:0] SIN_B = 15'd20953;
	localparam logic [11:0] SIN_C = 12'd2285;

	localparam logic [15:0] Q15_ONE       = 16'h8000;
	localparam logic [31:0] PHASE_QUARTER = 32'h4000_0000;

	typedef logic signed [15:0] q15_t;

endpackage

@@ sv/ppc_if.sv @@
// request channels of the plasma pixel colour block: pixel in, colour out, register write
// depends on ppc_pkg
interface ppc_pix_if;
	logic        valid;
	logic        ready;
	logic [7:0]  column;
	logic [7:0]  line;
	logic [23:0] frame_time;

	modport source (output valid, column, line, frame_time, input ready);
	modport sink (input valid, column, line, frame_time, output ready);
endinterface

interface ppc_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

interface ppc_cfg_if;
	import ppc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [15:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ sv/ppc_sine.sv @@
// four-stage pipelined sine of a phase in turns, q1.15 result
// depends on ppc_pkg
module ppc_sine (
	input  logic         clk,
	input  logic         en,
	input  logic [31:0]  phase,
	output ppc_pkg::q15_t sine
);
	import ppc_pkg::*;

	logic [15:0] zf, z;
	logic [31:0] zz, z2u, zv;
	logic [27:0] z2c;
	logic [16:0] mag;
	logic [14:0] mag_c;
	logic [15:0] z_s1, z_s2, z_s3;
	logic        neg_s1, neg_s2, neg_s3;
	logic [15:0] z2_s1, z2_s2;
	logic [14:0] u_s2;
	logic [15:0] v_s3;

	always_comb begin
		// fold odd quadrants onto the rising quarter
		zf = {1'b0, phase[29:16], 1'b0};
		z = phase[30] ? Q15_ONE - zf : zf;
		zz = z * z;
		z2c = z2_s1 * SIN_C;
		z2u = z2_s2 * u_s2;
		zv = z_s3 * v_s3;
		mag = zv[31:15];
		mag_c = (mag > 17'd32767) ? 15'h7FFF : mag[14:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1 <= z;
			neg_s1 <= phase[31];
			z2_s1 <= zz[30:15];

			z_s2 <= z_s1;
			neg_s2 <= neg_s1;
			z2_s2 <= z2_s1;
			u_s2 <= SIN_B - 15'(z2c[27:15]);

			z_s3 <= z_s2;
			neg_s3 <= neg_s2;
			v_s3 <= SIN_A - z2u[30:15];

			sine <= neg_s3 ? 16'(-$signed({1'b0, mag_c})) : $signed({1'b0, mag_c});
		end
	end

endmodule

@@ sv/plasma_pixel_color.sv @@
// plasma pixel colour generator, top level
// depends on ppc_pkg, ppc_if and ppc_sine
//
// One pixel per clock while the skid is empty; a request on pix is taken in every such cycle,
// and its colour reaches rgb through sixteen pipeline stages: coordinate lookup, the time phase
// built from split partial products over four stages, a four-stage sine, the outer phase over
// three stages and a second four-stage sine, followed by the output register. A one-entry skid
// behind the output register takes one more colour while a colour waits, so the pipe keeps
// moving; pix.ready drops only once that skid is full.
// Registers are written through cfg, which is always ready, and must be changed only while no
// pixel is in flight.
module plasma_pixel_color #(
	parameter int FRAME_WIDTH  = ppc_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = ppc_pkg::FRAME_HEIGHT_DEF
) (
	input logic       clk,
	input logic       arst_n,
	ppc_cfg_if.sink   cfg,
	ppc_pix_if.sink   pix,
	ppc_rgb_if.source rgb
);
	import ppc_pkg::*;

	localparam int PIPE_DEPTH = 16;
	localparam logic [31:0] RED_BIAS = 32'h4000_0000;

	q15_t x_tab [COORD_RANGE];
	q15_t y_tab [COORD_RANGE];

	q15_t gain_q [4];
	q15_t sweep_q [3];
	q15_t tgain [NUM_CH];
	q15_t ogain [NUM_CH];

	logic                  en, push, take;
	logic                  load_new, load_skid, load_from_skid;
	logic [PIPE_DEPTH:1]   vld_q;
	logic                  out_vld_q, skid_vld_q;

	q15_t               x_s1, y_s1;
	logic [23:0]        t_s1, t_s2;
	logic [52:0]        tk_s2;
	logic [51:0]        tkg_s2;
	logic signed [31:0] ys_s2, xs_s2;
	logic signed [43:0] tg_lo_s3 [NUM_CH];
	logic signed [42:0] tg_hi_s3 [NUM_CH];
	logic signed [42:0] sw_lo_s3, sw_hi_s3;
	logic signed [56:0] yst_s3, xst_s3;
	logic [51:0]        ta_s4 [NUM_CH];
	logic [53:0]        rb_lo_s4, bb_lo_s4;
	logic signed [53:0] rb_hi_s4, bb_hi_s4;
	logic [63:0]        red_p, blue_p;
	logic [31:0]        ph_s5 [NUM_CH];
	q15_t               w_s9 [NUM_CH];
	logic signed [31:0] xg_s9 [NUM_CH];
	logic signed [47:0] xgw_s10 [NUM_CH];
	logic [45:0]        op_lo_s11 [NUM_CH];
	logic signed [46:0] op_hi_s11 [NUM_CH];
	logic [31:0]        op_s12 [NUM_CH];
	q15_t               s_s16 [NUM_CH];
	q15_t               x_dly_q [2:PIPE_DEPTH];

	logic signed [31:0] red_prod;
	logic [31:0]        red_sum;
	logic [7:0]         res [NUM_CH];
	logic [7:0]         out_q [NUM_CH];
	logic [7:0]         skid_q [NUM_CH];

	function automatic logic [63:0] join64(input logic signed [63:0] hi,
		input logic signed [63:0] lo, input int unsigned sh);
		return 64'(hi <<< sh) + lo;
	endfunction

	// coordinate tables, saturated just under one beyond the frame
	for (genvar i = 0; i < COORD_RANGE; i++) begin : g_coord
		localparam int XV = (i >= FRAME_WIDTH) ? 32767 :
			((2 * i - FRAME_WIDTH) * 32768) / FRAME_WIDTH;
		localparam int YV = (i >= FRAME_HEIGHT) ? 32767 :
			((2 * i - FRAME_HEIGHT) * 32768) / FRAME_HEIGHT;
		assign x_tab[i] = 16'(XV);
		assign y_tab[i] = 16'(YV);
	end

	assign tgain[CH_RED]   = gain_q[1];
	assign tgain[CH_GREEN] = gain_q[2];
	assign tgain[CH_BLUE]  = gain_q[3];
	assign ogain[CH_RED]   = gain_q[0];
	assign ogain[CH_GREEN] = gain_q[2];
	assign ogain[CH_BLUE]  = gain_q[1];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) gain_q[k] <= '0;
			for (int k = 0; k < 3; k++) sweep_q[k] <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_GAIN_ZERO:  gain_q[0] <= cfg.data;
				REG_GAIN_ONE:   gain_q[1] <= cfg.data;
				REG_GAIN_TWO:   gain_q[2] <= cfg.data;
				REG_GAIN_THREE: gain_q[3] <= cfg.data;
				REG_SWEEP_ZERO: sweep_q[0] <= cfg.data;
				REG_SWEEP_ONE:  sweep_q[1] <= cfg.data;
				REG_SWEEP_TWO:  sweep_q[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	// the whole pipe moves unless the skid holds a colour
	assign en = !skid_vld_q;
	assign pix.ready = en;
	assign push = en && vld_q[PIPE_DEPTH];
	assign take = out_vld_q && rgb.ready;
	assign load_new = push && !(out_vld_q && !take);
	assign load_skid = push && out_vld_q && !take;
	assign load_from_skid = skid_vld_q && take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (en) vld_q <= {vld_q[PIPE_DEPTH-1:1], pix.valid};
			if (load_new || load_from_skid) out_vld_q <= 1'b1;
			else if (take) out_vld_q <= 1'b0;
			if (load_skid) skid_vld_q <= 1'b1;
			else if (load_from_skid) skid_vld_q <= 1'b0;
		end
	end

	always_comb begin
		red_p = {ta_s4[CH_RED], 12'd0} + join64(rb_hi_s4, rb_lo_s4, 29);
		blue_p = {ta_s4[CH_BLUE], 12'd0} + join64(bb_hi_s4, bb_lo_s4, 29);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x_tab[pix.column];
			y_s1 <= y_tab[pix.line];
			t_s1 <= pix.frame_time;

			tk_s2 <= t_s1 * K_RATE;
			tkg_s2 <= t_s1 * K_GREEN_SWEEP;
			ys_s2 <= y_s1 * sweep_q[0];
			xs_s2 <= x_s1 * sweep_q[2];
			t_s2 <= t_s1;

			for (int ch = 0; ch < NUM_CH; ch++) begin
				tg_lo_s3[ch] <= $signed({1'b0, tk_s2[26:0]}) * tgain[ch];
				tg_hi_s3[ch] <= $signed({1'b0, tk_s2[52:27]}) * tgain[ch];
			end
			sw_lo_s3 <= $signed({1'b0, tkg_s2[25:0]}) * sweep_q[1];
			sw_hi_s3 <= $signed({1'b0, tkg_s2[51:26]}) * sweep_q[1];
			yst_s3 <= ys_s2 * $signed({1'b0, t_s2});
			xst_s3 <= xs_s2 * $signed({1'b0, t_s2});

			ta_s4[CH_RED] <= 52'(join64(tg_hi_s3[CH_RED], tg_lo_s3[CH_RED], 27));
			ta_s4[CH_GREEN] <= 52'(join64(tg_hi_s3[CH_GREEN], tg_lo_s3[CH_GREEN], 27)
				+ join64(sw_hi_s3, sw_lo_s3, 26));
			ta_s4[CH_BLUE] <= 52'(join64(tg_hi_s3[CH_BLUE], tg_lo_s3[CH_BLUE], 27));
			rb_lo_s4 <= yst_s3[28:0] * K_RED_SWEEP;
			rb_hi_s4 <= $signed(yst_s3[56:29]) * $signed({1'b0, K_RED_SWEEP});
			bb_lo_s4 <= xst_s3[28:0] * K_BLUE_SWEEP;
			bb_hi_s4 <= $signed(xst_s3[56:29]) * $signed({1'b0, K_BLUE_SWEEP});

			ph_s5[CH_RED] <= red_p[63:32];
			// green runs on a cosine
			ph_s5[CH_GREEN] <= ta_s4[CH_GREEN][51:20] + PHASE_QUARTER;
			ph_s5[CH_BLUE] <= blue_p[63:32];

			for (int ch = 0; ch < NUM_CH; ch++) begin
				xg_s9[ch] <= x_dly_q[8] * ogain[ch];
				xgw_s10[ch] <= xg_s9[ch] * w_s9[ch];
				op_lo_s11[ch] <= xgw_s10[ch][23:0] * K_OUTER;
				op_hi_s11[ch] <= $signed(xgw_s10[ch][47:24]) * $signed({1'b0, K_OUTER});
				op_s12[ch] <= 32'(join64(op_hi_s11[ch], op_lo_s11[ch], 24) >> 32);
			end

			x_dly_q[2] <= x_s1;
			for (int k = 3; k <= PIPE_DEPTH; k++) x_dly_q[k] <= x_dly_q[k-1];
		end
	end

	for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
		ppc_sine u_inner (.clk(clk), .en(en), .phase(ph_s5[c]), .sine(w_s9[c]));
		ppc_sine u_outer (.clk(clk), .en(en), .phase(op_s12[c]), .sine(s_s16[c]));
	end

	always_comb begin
		red_prod = x_dly_q[PIPE_DEPTH] * s_s16[CH_RED];
		// always positive and below two to the 31
		red_sum = $unsigned(red_prod) + RED_BIAS;
		res[CH_RED] = red_sum[31] ? 8'hFF : red_sum[30:23];
		res[CH_GREEN] = {~s_s16[CH_GREEN][15], s_s16[CH_GREEN][14:8]};
		res[CH_BLUE] = {~s_s16[CH_BLUE][15], s_s16[CH_BLUE][14:8]};
	end

	always_ff @(posedge clk) begin
		if (load_new) out_q <= res;
		else if (load_from_skid) out_q <= skid_q;
		if (load_skid) skid_q <= res;
	end

	assign rgb.valid = out_vld_q;
	assign rgb.red = out_q[CH_RED];
	assign rgb.green = out_q[CH_GREEN];
	assign rgb.blue = out_q[CH_BLUE];

endmodule

@@ sv/ppc_checker.sv @@
// port-level checks on the plasma pixel colour block, bound to the top level
// depends on plasma_pixel_color_assert.svh and plasma_pixel_color
`include "plasma_pixel_color_assert.svh"

module ppc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pix_ready,
	input logic        rgb_valid,
	input logic        rgb_ready,
	input logic [23:0] rgb_data
);

	`PPC_ASSERT_RUN(a_rgb_hold, rgb_valid && !rgb_ready |=> rgb_valid, "colour dropped while stalled")
	`PPC_ASSERT_RUN(a_rgb_stable, rgb_valid && !rgb_ready |=> $stable(rgb_data), "colour changed while stalled")
	// an empty output register means the skid is empty too
	`PPC_ASSERT_ALL(a_ready_when_empty, !rgb_valid |-> pix_ready, "pixel side stalled with no colour waiting")
	// back-pressure only after the output has been held
	`PPC_ASSERT_RUN(a_ready_drop, !pix_ready |-> rgb_valid && $past(rgb_valid && !rgb_ready), "pixel side stalled without a held colour")

endmodule

bind plasma_pixel_color ppc_checker u_ppc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.pix_ready(pix.ready),
	.rgb_valid(rgb.valid),
	.rgb_ready(rgb.ready),
	.rgb_data({rgb.red, rgb.green, rgb.blue})
);
